// ===== sv/ppmcd_pkg.sv =====
// ----------------------------------------------------------------------------
// ppmcd_pkg
// Shared types and constants of the pulse-position channel decoder.
// ----------------------------------------------------------------------------
package ppmcd_pkg;

    // timing and channel geometry
    localparam int TIME_W   = 16;
    localparam int NUM_CH   = 6;
    localparam int SLOT_W   = 3;
    localparam int VALUE_W  = 8;
    localparam int RDCH_W   = 8;
    localparam int CFG_IDX_W = 2;

    // register reset values
    localparam logic [TIME_W-1:0] CENTER_RESET = 16'd2650;
    localparam logic [TIME_W-1:0] SYNC_RESET   = 16'd10000;

    // slot index value that means no slot armed or written
    localparam logic [SLOT_W-1:0] SLOT_NONE = 3'(NUM_CH);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CENTER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC   = 2'd1;

    // edge kinds
    typedef enum logic [1:0] {
        MODE_FALL = 2'd0,
        MODE_RISE = 2'd1,
        MODE_LOST = 2'd2
    } mode_t;

    typedef logic signed [VALUE_W-1:0] chan_value_t;

    // one result request
    typedef struct packed {
        logic        signal_lost;
        logic        sync_seen;
        logic [SLOT_W-1:0] stored_slot;
        chan_value_t read_value;
    } result_t;

    // reset value of a slot: 1..5, then zero
    function automatic chan_value_t slot_reset_value(input int idx);
        chan_value_t v;
        v = (idx < 5) ? chan_value_t'(idx + 1) : '0;
        return v;
    endfunction

    // channel number modulo six, by reciprocal multiply (171/1024) and correction
    function automatic logic [SLOT_W-1:0] channel_mod(input logic [RDCH_W-1:0] x);
        logic [15:0] prod;
        logic [5:0]  quot;
        logic [RDCH_W-1:0] rem;
        prod = 16'(x) * 16'd171;
        quot = prod[15:10];
        rem  = x - RDCH_W'(quot) * RDCH_W'(6);
        return rem[SLOT_W-1:0];
    endfunction

endpackage

// ===== sv/ppmcd_scale.sv =====
// ----------------------------------------------------------------------------
// ppmcd_scale
// Maps a pulse width to a saturated channel value: (width - center) / 8,
// truncated toward zero and clamped to -127..127.
// ----------------------------------------------------------------------------
module ppmcd_scale
    import ppmcd_pkg::*;
(
    input  logic [TIME_W-1:0] width,
    input  logic [TIME_W-1:0] center,
    output chan_value_t       value
);

    logic signed [TIME_W:0]   diff;
    logic signed [TIME_W:0]   biased;
    logic signed [TIME_W-3:0] quot;

    // signed difference, biased so the shift truncates toward zero
    always_comb
    begin
        diff   = $signed({1'b0, width}) - $signed({1'b0, center});
        biased = diff[TIME_W] ? diff + (TIME_W+1)'(7) : diff;
        quot   = (TIME_W-2)'(biased >>> 3);
    end

    // saturate to the symmetric channel range
    always_comb
    begin
        if (quot > (TIME_W-2)'(127))
        begin
            value = 8'sd127;
        end
        else if (quot < -(TIME_W-2)'(127))
        begin
            value = -8'sd127;
        end
        else
        begin
            value = chan_value_t'(quot);
        end
    end

endmodule

// ===== sv/ppm_channel_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// ppm_channel_decoder_unit
// Pulse-position RC frame decoder driven by timestamped edge requests.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one edge request: s_tuser is the edge kind (falling,
//   rising, signal lost), s_tdata carries the timestamp and the channel to
//   read back. Every request gives exactly one result on the m_* channel:
//   the read-back channel value, the slot written, and sync / lost flags.
//   cfg_* writes center_ticks (index 0) and sync_threshold (index 1); it is
//   always ready. The user writes it only while the decoder is idle; unenforced.
// Throughput:
//   results are registered; one request per cycle is sustained while
//   s_tready is high. Decoder state updates at the accepting edge, so the
//   next request sees it at once.
// Reset:
//   rst_n clears the edge state, parks the slot index at "none armed", and
//   loads slots 1,2,3,4,5,0 and the register defaults.
// Stall:
//   an output register plus a one-entry skid buffer hold results while
//   m_tready is low; s_tready drops only when both are full.
// ----------------------------------------------------------------------------
module ppm_channel_decoder_unit
    import ppmcd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    // request stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [23:0]          s_tdata,   // timestamp[15:0], read_channel[23:16]
    input  logic [1:0]           s_tuser,   // mode[1:0]

    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // read_value[7:0], stored_slot[10:8],
                                            // sync_seen[11], signal_lost[12], zero[15:13]

    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TIME_W-1:0]    cfg_data
);

    logic [TIME_W-1:0] center_reg;
    logic [TIME_W-1:0] sync_thr_reg;

    logic              awaiting_reg, awaiting_next;
    logic [TIME_W-1:0] start_reg, start_next;
    logic [SLOT_W-1:0] slot_idx_reg, slot_idx_next;
    chan_value_t       chan_reg  [NUM_CH];
    chan_value_t       chan_next [NUM_CH];

    result_t           out_reg, skid_reg, result_next;
    logic              out_valid_reg, skid_valid_reg;

    logic              accept;
    logic              out_free;
    logic [TIME_W-1:0] ts;
    logic [RDCH_W-1:0] rd_raw;
    logic [SLOT_W-1:0] rd_slot;
    logic [TIME_W-1:0] width;
    chan_value_t       scaled;

    // request fields
    assign ts      = s_tdata[TIME_W-1:0];
    assign rd_raw  = s_tdata[TIME_W+RDCH_W-1:TIME_W];
    assign rd_slot = channel_mod(rd_raw);
    assign width   = ts - start_reg;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !skid_valid_reg;
    assign out_free = !out_valid_reg || m_tready;
    assign cfg_ready = 1'b1;

    ppmcd_scale u_scale
    (
        .width  (width),
        .center (center_reg),
        .value  (scaled)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg   <= CENTER_RESET;
            sync_thr_reg <= SYNC_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_CENTER: center_reg   <= cfg_data;
                REG_SYNC:   sync_thr_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // edge decode and slot update
    always_comb
    begin
        awaiting_next = awaiting_reg;
        start_next    = start_reg;
        slot_idx_next = slot_idx_reg;
        for (int i = 0; i < NUM_CH; i++)
        begin
            chan_next[i] = chan_reg[i];
        end
        result_next.stored_slot = SLOT_NONE;
        result_next.sync_seen   = 1'b0;
        result_next.signal_lost = 1'b0;

        case (s_tuser)
            MODE_FALL:
            begin
                if (!awaiting_reg)
                begin
                    start_next    = ts;
                    awaiting_next = 1'b1;
                end
            end
            MODE_RISE:
            begin
                if (awaiting_reg)
                begin
                    awaiting_next = 1'b0;
                    if (width >= sync_thr_reg)
                    begin
                        slot_idx_next         = '0;
                        result_next.sync_seen = 1'b1;
                    end
                    else if (slot_idx_reg < SLOT_NONE)
                    begin
                        chan_next[slot_idx_reg] = scaled;
                        result_next.stored_slot = slot_idx_reg;
                        slot_idx_next           = slot_idx_reg + SLOT_W'(1);
                    end
                end
            end
            MODE_LOST:
            begin
                for (int i = 0; i < NUM_CH; i++)
                begin
                    chan_next[i] = '0;
                end
                slot_idx_next           = SLOT_NONE;
                result_next.signal_lost = 1'b1;
            end
            default: ;
        endcase

        result_next.read_value = chan_next[rd_slot];
    end

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg <= 1'b0;
            start_reg    <= '0;
            slot_idx_reg <= SLOT_NONE;
            for (int i = 0; i < NUM_CH; i++)
            begin
                chan_reg[i] <= slot_reset_value(i);
            end
        end
        else if (accept)
        begin
            awaiting_reg <= awaiting_next;
            start_reg    <= start_next;
            slot_idx_reg <= slot_idx_next;
            for (int i = 0; i < NUM_CH; i++)
            begin
                chan_reg[i] <= chan_next[i];
            end
        end
    end

    // output register and skid buffer valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // result payloads
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_reg <= skid_valid_reg ? skid_reg : result_next;
        end
        else if (accept)
        begin
            skid_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg.signal_lost, out_reg.sync_seen,
                       out_reg.stored_slot, out_reg.read_value};

endmodule
